FILE: hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, sequencer states and the command record shared by the
// front end, the command queue and the line sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_STOP     = 3'd1,
    MODE_WRITE    = 3'd2,
    MODE_READ     = 3'd3,
    MODE_WAIT_ACK = 3'd4,
    MODE_PROBE    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_STOP,
    ST_SEND,
    ST_WACK,
    ST_RBIT,
    ST_RACK
  } seq_state_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] data;
    logic       send_ack;
    logic [7:0] samples;
    logic       ack_sample;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [2:0] PROBE_LAST = 3'd4;

endpackage

FILE: hdl/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Turns bus commands into the ordered sequence of SCL and SDA line changes.
//
//   Channel  Handshake               Payload
//   cmd      cmd_valid / cmd_ready   mode, data_byte, send_ack, sda_samples,
//                                    ack_sample
//   line     line_valid / line_ready scl_drive, sda_drive, read_data,
//                                    ack_level, last
//
// A command leaves the queue first; the sequencer then issues its line changes.
// The line sequencer handles one command at a time; the queue ahead of it
// keeps taking commands until it is full. Unused mode codes are taken and
// dropped. After reset both lines read as released and the queue is empty.
// A stalled line transfer holds the sequencer without losing a step.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic [2:0] mode,
  input  logic [7:0] data_byte,
  input  logic       send_ack,
  input  logic [7:0] sda_samples,
  input  logic       ack_sample,
  output logic       line_valid,
  input  logic       line_ready,
  output logic       scl_drive,
  output logic       sda_drive,
  output logic [7:0] read_data,
  output logic       ack_level,
  output logic       last
);

  i2cm_pkg::q_status_t q_status;
  i2cm_pkg::cmd_t      push_cmd;
  i2cm_pkg::cmd_t      head;
  logic                push;
  logic                pop;

  i2cm_front u_front (
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .mode        (mode),
    .data_byte   (data_byte),
    .send_ack    (send_ack),
    .sda_samples (sda_samples),
    .ack_sample  (ack_sample),
    .q_status    (q_status),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  i2cm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .scl_drive  (scl_drive),
    .sda_drive  (sda_drive),
    .read_data  (read_data),
    .ack_level  (ack_level),
    .last       (last)
  );

endmodule

FILE: hdl/i2cm_front.sv
// ----------------------------------------------------------------------------
// I2C master command front end
// Accepts command transfers, decodes the mode and queues the commands that
// produce bus activity. Unused mode codes are accepted and dropped.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  logic [2:0]           mode,
  input  logic [7:0]           data_byte,
  input  logic                 send_ack,
  input  logic [7:0]           sda_samples,
  input  logic                 ack_sample,
  input  i2cm_pkg::q_status_t  q_status,
  output logic                 push,
  output i2cm_pkg::cmd_t       push_cmd
);

  logic mode_known;

  assign mode_known = mode inside {i2cm_pkg::MODE_START, i2cm_pkg::MODE_STOP,
                                   i2cm_pkg::MODE_WRITE, i2cm_pkg::MODE_READ,
                                   i2cm_pkg::MODE_WAIT_ACK, i2cm_pkg::MODE_PROBE};

  assign cmd_ready = !q_status.full;
  assign push      = cmd_valid && cmd_ready && mode_known;

  always_comb begin
    push_cmd.mode       = i2cm_pkg::mode_t'(mode);
    push_cmd.data       = data_byte;
    push_cmd.send_ack   = send_ack;
    push_cmd.samples    = sda_samples;
    push_cmd.ack_sample = ack_sample;
  end

endmodule

FILE: hdl/i2cm_queue.sv
// ----------------------------------------------------------------------------
// I2C master command queue
// A short first-in first-out queue of decoded commands between the front
// end and the line sequencer.
// ----------------------------------------------------------------------------
module i2cm_queue #(
  parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  i2cm_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output i2cm_pkg::cmd_t      head,
  output i2cm_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  i2cm_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hdl/i2cm_back.sv
// ----------------------------------------------------------------------------
// I2C master line sequencer
// Takes one command at a time from the queue and steps through its bus
// segments, issuing one SCL or SDA line change per step into an output
// register.
// ----------------------------------------------------------------------------
module i2cm_back (
  input  logic                clk,
  input  logic                rst,
  input  i2cm_pkg::cmd_t      head,
  input  i2cm_pkg::q_status_t q_status,
  output logic                pop,
  output logic                line_valid,
  input  logic                line_ready,
  output logic                scl_drive,
  output logic                sda_drive,
  output logic [7:0]          read_data,
  output logic                ack_level,
  output logic                last
);

  typedef struct packed {
    logic on_scl;
    logic level;
    logic seg_end;
  } step_t;

  function automatic i2cm_pkg::seq_state_t probe_seg(input logic [2:0] idx);
    case (idx)
      3'd0:    probe_seg = i2cm_pkg::ST_STOP;
      3'd1:    probe_seg = i2cm_pkg::ST_START;
      3'd2:    probe_seg = i2cm_pkg::ST_SEND;
      3'd3:    probe_seg = i2cm_pkg::ST_WACK;
      default: probe_seg = i2cm_pkg::ST_STOP;
    endcase
  endfunction

  i2cm_pkg::seq_state_t state, state_next;
  i2cm_pkg::cmd_t       cmd, cmd_next;
  logic [1:0]           sub, sub_next;
  logic [2:0]           bit_cnt, bit_cnt_next;
  logic [2:0]           probe_idx, probe_idx_next;
  logic [7:0]           shreg, shreg_next;
  logic                 scl_level, sda_level;
  logic                 adv;
  logic                 is_last;
  step_t                step;

  assign adv = (state != i2cm_pkg::ST_IDLE) && (!line_valid || line_ready);
  assign pop = (state == i2cm_pkg::ST_IDLE) && !q_status.empty;
  assign is_last = step.seg_end &&
                   ((cmd.mode != i2cm_pkg::MODE_PROBE) || (probe_idx == i2cm_pkg::PROBE_LAST));

  always_comb begin
    step = '0;
    case (state)
      i2cm_pkg::ST_START: begin
        case (sub)
          2'd0:    step = '{on_scl: 1'b0, level: 1'b1, seg_end: 1'b0};
          2'd1:    step = '{on_scl: 1'b1, level: 1'b1, seg_end: 1'b0};
          2'd2:    step = '{on_scl: 1'b0, level: 1'b0, seg_end: 1'b0};
          default: step = '{on_scl: 1'b1, level: 1'b0, seg_end: 1'b1};
        endcase
      end
      i2cm_pkg::ST_STOP: begin
        case (sub)
          2'd0:    step = '{on_scl: 1'b0, level: 1'b0, seg_end: 1'b0};
          2'd1:    step = '{on_scl: 1'b1, level: 1'b1, seg_end: 1'b0};
          default: step = '{on_scl: 1'b0, level: 1'b1, seg_end: 1'b1};
        endcase
      end
      i2cm_pkg::ST_SEND: begin
        case (sub)
          2'd0:    step = '{on_scl: 1'b0, level: shreg[7], seg_end: 1'b0};
          2'd1:    step = '{on_scl: 1'b1, level: 1'b1, seg_end: 1'b0};
          2'd2:    step = '{on_scl: 1'b1, level: 1'b0, seg_end: 1'b0};
          default: step = '{on_scl: 1'b0, level: 1'b1, seg_end: 1'b1};
        endcase
      end
      i2cm_pkg::ST_WACK: begin
        case (sub)
          2'd0:    step = '{on_scl: 1'b0, level: 1'b1, seg_end: 1'b0};
          2'd1:    step = '{on_scl: 1'b1, level: 1'b1, seg_end: 1'b0};
          default: step = '{on_scl: 1'b1, level: 1'b0, seg_end: 1'b1};
        endcase
      end
      i2cm_pkg::ST_RBIT: begin
        case (sub)
          2'd0:    step = '{on_scl: 1'b1, level: 1'b1, seg_end: 1'b0};
          default: step = '{on_scl: 1'b1, level: 1'b0, seg_end: 1'b0};
        endcase
      end
      i2cm_pkg::ST_RACK: begin
        if (cmd.send_ack) begin
          case (sub)
            2'd0:    step = '{on_scl: 1'b0, level: 1'b0, seg_end: 1'b0};
            2'd1:    step = '{on_scl: 1'b1, level: 1'b1, seg_end: 1'b0};
            2'd2:    step = '{on_scl: 1'b1, level: 1'b0, seg_end: 1'b0};
            default: step = '{on_scl: 1'b0, level: 1'b1, seg_end: 1'b1};
          endcase
        end else begin
          case (sub)
            2'd0:    step = '{on_scl: 1'b0, level: 1'b1, seg_end: 1'b0};
            2'd1:    step = '{on_scl: 1'b1, level: 1'b1, seg_end: 1'b0};
            default: step = '{on_scl: 1'b1, level: 1'b0, seg_end: 1'b1};
          endcase
        end
      end
      default: step = '0;
    endcase
  end

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    sub_next       = sub;
    bit_cnt_next   = bit_cnt;
    probe_idx_next = probe_idx;
    shreg_next     = shreg;
    if (pop) begin
      cmd_next       = head;
      shreg_next     = head.data;
      sub_next       = '0;
      bit_cnt_next   = '0;
      probe_idx_next = '0;
      case (head.mode)
        i2cm_pkg::MODE_START:    state_next = i2cm_pkg::ST_START;
        i2cm_pkg::MODE_STOP:     state_next = i2cm_pkg::ST_STOP;
        i2cm_pkg::MODE_WRITE:    state_next = i2cm_pkg::ST_SEND;
        i2cm_pkg::MODE_READ:     state_next = i2cm_pkg::ST_RBIT;
        i2cm_pkg::MODE_WAIT_ACK: state_next = i2cm_pkg::ST_WACK;
        i2cm_pkg::MODE_PROBE:    state_next = i2cm_pkg::ST_STOP;
        default:                 state_next = i2cm_pkg::ST_IDLE;
      endcase
    end else if (adv) begin
      if (step.seg_end) begin
        sub_next     = '0;
        bit_cnt_next = '0;
        if (is_last) begin
          state_next = i2cm_pkg::ST_IDLE;
        end else begin
          probe_idx_next = probe_idx + 3'd1;
          state_next     = probe_seg(probe_idx + 3'd1);
        end
      end else begin
        case (state)
          i2cm_pkg::ST_SEND: begin
            if (sub == 2'd2 && bit_cnt != 3'd7) begin
              sub_next     = '0;
              bit_cnt_next = bit_cnt + 3'd1;
              shreg_next   = {shreg[6:0], 1'b0};
            end else begin
              sub_next = sub + 2'd1;
            end
          end
          i2cm_pkg::ST_RBIT: begin
            if (sub == 2'd1) begin
              sub_next = '0;
              if (bit_cnt == 3'd7) begin
                bit_cnt_next = '0;
                state_next   = i2cm_pkg::ST_RACK;
              end else begin
                bit_cnt_next = bit_cnt + 3'd1;
              end
            end else begin
              sub_next = sub + 2'd1;
            end
          end
          default: sub_next = sub + 2'd1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= i2cm_pkg::ST_IDLE;
      sub       <= '0;
      bit_cnt   <= '0;
      probe_idx <= '0;
    end else begin
      state     <= state_next;
      sub       <= sub_next;
      bit_cnt   <= bit_cnt_next;
      probe_idx <= probe_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd   <= cmd_next;
    shreg <= shreg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      line_valid <= 1'b0;
    end else if (adv) begin
      line_valid <= 1'b1;
      if (step.on_scl) begin
        scl_level <= step.level;
      end else begin
        sda_level <= step.level;
      end
    end else if (line_ready) begin
      line_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last      <= is_last;
      read_data <= (is_last && cmd.mode == i2cm_pkg::MODE_READ) ? cmd.samples : 8'd0;
      ack_level <= is_last && (cmd.mode == i2cm_pkg::MODE_WAIT_ACK ||
                               cmd.mode == i2cm_pkg::MODE_PROBE) && cmd.ack_sample;
    end
  end

  assign scl_drive = scl_level;
  assign sda_drive = sda_level;

endmodule

FILE: hdl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Port-level properties of the line channel, attached to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic       clk,
  input logic       rst,
  input logic       line_valid,
  input logic       line_ready,
  input logic       scl_drive,
  input logic       sda_drive,
  input logic [7:0] read_data,
  input logic       ack_level,
  input logic       last
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !line_valid)
    else $error("line transfer offered right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    line_valid && !line_ready |=> line_valid &&
      $stable({scl_drive, sda_drive, read_data, ack_level, last}))
    else $error("stalled line transfer changed");

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    line_valid && !last |-> read_data == 8'd0 && !ack_level)
    else $error("read data or acknowledge shown before the final transfer");

  a_end_levels: assert property (@(posedge clk) disable iff (rst)
    line_valid && last |-> sda_drive || !scl_drive)
    else $error("command ended with SDA held low and SCL released");

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (.*);

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives bus commands through the valid/ready command port with bursty
// timing, predicts every SCL/SDA line change each command produces, and
// checks the line port transfer by transfer while the receiver stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 480;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [2:0] mode;
    logic [7:0] data;
    logic       send_ack;
    logic [7:0] samples;
    logic       ack_sample;
    bit         hold;
  } bus_cmd_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rd;
    logic       ack;
    logic       last;
  } line_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_ready;
  logic [2:0] mode = 3'd0;
  logic [7:0] data_byte = 8'h00;
  logic       send_ack = 1'b0;
  logic [7:0] sda_samples = 8'h00;
  logic       ack_sample = 1'b0;
  logic       line_valid;
  logic       line_ready = 1'b0;
  logic       scl_drive;
  logic       sda_drive;
  logic [7:0] read_data;
  logic       ack_level;
  logic       last;

  bus_cmd_t pending_cmds[$];
  line_t    expected_lines[$];
  bus_cmd_t cur_cmd;
  logic     model_scl = 1'b1;
  logic     model_sda = 1'b1;
  int       bus_items = 0;
  int       mismatches = 0;
  int       burst_left = 1;
  int       gap_left = 0;
  int       idle_cycles = 0;
  logic [5:0] stall_phase = 6'd0;
  int       stall_style = 0;
  line_t    seen_line;
  line_t    want_line;

  i2c_master_bit_engine dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .mode(mode), .data_byte(data_byte), .send_ack(send_ack),
    .sda_samples(sda_samples), .ack_sample(ack_sample),
    .line_valid(line_valid), .line_ready(line_ready),
    .scl_drive(scl_drive), .sda_drive(sda_drive), .read_data(read_data),
    .ack_level(ack_level), .last(last)
  );

  always #2 clk = ~clk;

  function automatic void put_line(logic scl, logic sda);
    line_t l;
    model_scl = scl;
    model_sda = sda;
    l = '{scl: scl, sda: sda, rd: 8'h00, ack: 1'b0, last: 1'b0};
    expected_lines.push_back(l);
  endfunction

  function automatic void set_scl(logic v);
    put_line(v, model_sda);
  endfunction

  function automatic void set_sda(logic v);
    put_line(model_scl, v);
  endfunction

  function automatic void line_start();
    set_sda(1'b1);
    set_scl(1'b1);
    set_sda(1'b0);
    set_scl(1'b0);
  endfunction

  function automatic void line_stop();
    set_sda(1'b0);
    set_scl(1'b1);
    set_sda(1'b1);
  endfunction

  function automatic void line_send(logic [7:0] value);
    logic [7:0] b;
    b = value;
    for (int i = 0; i < 8; i++) begin
      set_sda(b[7]);
      set_scl(1'b1);
      set_scl(1'b0);
      if (i == 7) set_sda(1'b1);
      b = b << 1;
    end
  endfunction

  function automatic void line_wait_ack();
    set_sda(1'b1);
    set_scl(1'b1);
    set_scl(1'b0);
  endfunction

  function automatic void line_read(logic ack);
    for (int i = 0; i < 8; i++) begin
      set_scl(1'b1);
      set_scl(1'b0);
    end
    if (ack) begin
      set_sda(1'b0);
      set_scl(1'b1);
      set_scl(1'b0);
      set_sda(1'b1);
    end else begin
      set_sda(1'b1);
      set_scl(1'b1);
      set_scl(1'b0);
    end
  endfunction

  function automatic void predict_lines(bus_cmd_t c);
    int         n0;
    line_t      tail;
    logic [7:0] rd;
    logic       ackv;
    n0 = expected_lines.size();
    rd = 8'h00;
    ackv = 1'b0;
    case (c.mode)
      i2cm_pkg::MODE_START: line_start();
      i2cm_pkg::MODE_STOP: line_stop();
      i2cm_pkg::MODE_WRITE: line_send(c.data);
      i2cm_pkg::MODE_READ: begin
        line_read(c.send_ack);
        rd = c.samples;
      end
      i2cm_pkg::MODE_WAIT_ACK: begin
        line_wait_ack();
        ackv = c.ack_sample;
      end
      i2cm_pkg::MODE_PROBE: begin
        line_stop();
        line_start();
        line_send(c.data);
        line_wait_ack();
        ackv = c.ack_sample;
        line_stop();
      end
      default: ;
    endcase
    if (expected_lines.size() > n0) begin
      tail = expected_lines.pop_back();
      tail.rd = rd;
      tail.ack = ackv;
      tail.last = 1'b1;
      expected_lines.push_back(tail);
    end
  endfunction

  task automatic add_cmd(logic [2:0] m, logic [7:0] d, logic sa, logic [7:0] s,
                         logic as, bit hold);
    bus_cmd_t c;
    c = '{mode: m, data: d, send_ack: sa, samples: s, ack_sample: as, hold: hold};
    pending_cmds.push_back(c);
    if (m != MODE_SPARE_6 && m != MODE_SPARE_7) bus_items++;
  endtask

  task automatic add_rand(logic [2:0] m, bit hold);
    add_cmd(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), hold);
  endtask

  // Command driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) predict_lines(cur_cmd);
      if (!cmd_valid || cmd_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].hold && expected_lines.size() != 0)) begin
          cur_cmd = pending_cmds.pop_front();
          cmd_valid <= 1'b1;
          mode <= cur_cmd.mode;
          data_byte <= cur_cmd.data;
          send_ack <= cur_cmd.send_ack;
          sda_samples <= cur_cmd.samples;
          ack_sample <= cur_cmd.ack_sample;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              4, 5, 6, 7: gap_left = $urandom_range(1, 4);
              8: gap_left = $urandom_range(5, 20);
              default: gap_left = $urandom_range(30, 60);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Line receiver: a new stall style is picked each time the six-bit phase counter wraps.
  always @(posedge clk) begin
    if (rst) begin
      line_ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == 6'd0) stall_style = $urandom_range(0, 3);
      case (stall_style)
        0: line_ready <= 1'b1;
        1: line_ready <= ($urandom_range(0, 3) != 0);
        2: line_ready <= ($urandom_range(0, 3) == 0);
        default: line_ready <= (stall_phase[2:0] == 3'd0);
      endcase
    end
  end

  // Line monitor.
  always @(posedge clk) begin
    if (!rst && line_valid && line_ready) begin
      seen_line = '{scl: scl_drive, sda: sda_drive, rd: read_data,
                    ack: ack_level, last: last};
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Line transfer with nothing expected: %s",
                   $sformatf("scl=%b sda=%b rd=%h ack=%b last=%b",
                             seen_line.scl, seen_line.sda, seen_line.rd,
                             seen_line.ack, seen_line.last));
      end else begin
        want_line = expected_lines.pop_front();
        if (seen_line !== want_line) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Line mismatch: expected %s, got %s",
                     $sformatf("scl=%b sda=%b rd=%h ack=%b last=%b",
                               want_line.scl, want_line.sda, want_line.rd,
                               want_line.ack, want_line.last),
                     $sformatf("scl=%b sda=%b rd=%h ack=%b last=%b",
                               seen_line.scl, seen_line.sda, seen_line.rd,
                               seen_line.ack, seen_line.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && cmd_ready) || (line_valid && line_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int reps;
    add_cmd(i2cm_pkg::MODE_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_cmd(i2cm_pkg::MODE_WRITE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_cmd(i2cm_pkg::MODE_WAIT_ACK, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_cmd(i2cm_pkg::MODE_WRITE, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0);
    add_cmd(i2cm_pkg::MODE_WAIT_ACK, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0);
    add_cmd(i2cm_pkg::MODE_WRITE, 8'hA5, 1'b0, 8'h5A, 1'b0, 1'b0);
    add_cmd(i2cm_pkg::MODE_READ, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b0);
    add_cmd(i2cm_pkg::MODE_READ, 8'h00, 1'b0, 8'hFF, 1'b0, 1'b0);
    add_cmd(i2cm_pkg::MODE_READ, 8'h3C, 1'b1, 8'h5A, 1'b0, 1'b0);
    add_cmd(i2cm_pkg::MODE_READ, 8'hC3, 1'b0, 8'hA5, 1'b1, 1'b0);
    add_cmd(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_cmd(i2cm_pkg::MODE_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0);
    add_cmd(i2cm_pkg::MODE_START, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1);
    add_cmd(i2cm_pkg::MODE_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_cmd(i2cm_pkg::MODE_WAIT_ACK, 8'h55, 1'b1, 8'hAA, 1'b0, 1'b0);
    add_cmd(i2cm_pkg::MODE_PROBE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_cmd(i2cm_pkg::MODE_PROBE, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0);
    add_cmd(i2cm_pkg::MODE_PROBE, 8'hD0, 1'b0, 8'h0F, 1'b0, 1'b0);
    add_cmd(MODE_SPARE_6, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0);
    add_cmd(MODE_SPARE_7, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_cmd(i2cm_pkg::MODE_STOP, 8'h81, 1'b0, 8'h18, 1'b1, 1'b0);

    // Random part: mostly complete bus transactions, some probes and noise.
    bus_items = 0;
    while (bus_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          add_rand(i2cm_pkg::MODE_START, $urandom_range(0, 39) == 0);
          add_rand(i2cm_pkg::MODE_WRITE, 1'b0);
          add_rand(i2cm_pkg::MODE_WAIT_ACK, 1'b0);
          reps = $urandom_range(1, 3);
          for (int i = 0; i < reps; i++) begin
            if ($urandom_range(0, 1) == 0) begin
              add_rand(i2cm_pkg::MODE_WRITE, 1'b0);
              add_rand(i2cm_pkg::MODE_WAIT_ACK, 1'b0);
            end else begin
              add_rand(i2cm_pkg::MODE_READ, 1'b0);
            end
          end
          add_rand(i2cm_pkg::MODE_STOP, 1'b0);
        end
        6, 7: add_rand(i2cm_pkg::MODE_PROBE, 1'b0);
        default: add_rand(3'($urandom_range(0, 7)), 1'b0);
      endcase
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_cmds.size() != 0 || cmd_valid) @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
